// ----- design/dcbac_pkg.sv -----
// Shared widths, register map and types for the dual-channel block average
// and calibration block. No dependencies.
package dcbac_pkg;

  localparam int SAMPLE_W = 12;
  localparam int SUM_W    = 18;
  localparam int REG_W    = 15;
  localparam int AVG_W    = 12;
  localparam int DIFF_W   = 17;
  localparam int PROD_W   = 33;
  localparam int OUT_W    = 30;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  localparam logic [REG_W-1:0] BIAS_RESET = REG_W'(0);
  localparam logic [REG_W-1:0] GAIN_RESET = REG_W'(256);

  // Saturation bounds of a result, in product width
  localparam logic signed [PROD_W-1:0] OUT_MAX =
    {{(PROD_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [PROD_W-1:0] OUT_MIN =
    {{(PROD_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

  // Register index (byte address bits [3:2])
  typedef enum logic [1:0] {
    REG_VOLT_BIAS = 2'd0,
    REG_VOLT_GAIN = 2'd1,
    REG_AMP_BIAS  = 2'd2,
    REG_AMP_GAIN  = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [REG_W-1:0] volt_bias;
    logic [REG_W-1:0] volt_gain;
    logic [REG_W-1:0] amp_bias;
    logic [REG_W-1:0] amp_gain;
  } cfg_t;

endpackage

// ----- design/dual_channel_block_average_calibrate.sv -----
// Dual-channel block average with bias and gain calibration, top level.
// A block's result passes through the block capture, divide, gain multiply and
// saturate/output registers in that order; a stage holds its item while out_stall_i stalls it.
// Throughput: one item per cycle while in_stall_o is low; one result per BLOCK_LEN items.
// Reset clears sums, counter and pipeline valids; gains reset to 1.0 (256),
// biases to 0.
module dual_channel_block_average_calibrate #(
  parameter int BLOCK_LEN = 50
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dcbac_pkg::ADDR_W-1:0]    paddr,
  input  logic [dcbac_pkg::DATA_W-1:0]    pwdata,
  output logic [dcbac_pkg::DATA_W-1:0]    prdata,
  output logic                            pready,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [dcbac_pkg::SAMPLE_W-1:0]  volt_sample_i,
  input  logic [dcbac_pkg::SAMPLE_W-1:0]  amp_sample_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [dcbac_pkg::OUT_W-1:0]     volt_value_o,
  output logic [dcbac_pkg::OUT_W-1:0]     amp_value_o
);
  import dcbac_pkg::*;

  cfg_t             cfg;
  logic             accept, last;
  logic [SUM_W-1:0] vblk, ablk;
  logic             blk_v_q, avg_v_q, prod_v_q, out_v_q;
  logic             blk_rdy, avg_rdy, prod_rdy, out_rdy;

  dcbac_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Stage ready chain: a stage takes new data when empty or draining
  assign out_rdy  = !out_v_q  || !out_stall_i;
  assign prod_rdy = !prod_v_q || out_rdy;
  assign avg_rdy  = !avg_v_q  || prod_rdy;
  assign blk_rdy  = !blk_v_q  || avg_rdy;

  assign in_stall_o = !blk_rdy;
  assign accept     = in_valid_i && blk_rdy;

  dcbac_accum #(.BLOCK_LEN(BLOCK_LEN)) u_accum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .volt_sample_i (volt_sample_i),
    .amp_sample_i  (amp_sample_i),
    .last_o        (last),
    .volt_blk_o    (vblk),
    .amp_blk_o     (ablk)
  );

  dcbac_chan #(.BLOCK_LEN(BLOCK_LEN)) u_volt (
    .clk_i     (clk_i),
    .avg_en_i  (avg_rdy && blk_v_q),
    .prod_en_i (prod_rdy && avg_v_q),
    .out_en_i  (out_rdy && prod_v_q),
    .blk_sum_i (vblk),
    .bias_i    (cfg.volt_bias),
    .gain_i    (cfg.volt_gain),
    .value_o   (volt_value_o)
  );

  dcbac_chan #(.BLOCK_LEN(BLOCK_LEN)) u_amp (
    .clk_i     (clk_i),
    .avg_en_i  (avg_rdy && blk_v_q),
    .prod_en_i (prod_rdy && avg_v_q),
    .out_en_i  (out_rdy && prod_v_q),
    .blk_sum_i (ablk),
    .bias_i    (cfg.amp_bias),
    .gain_i    (cfg.amp_gain),
    .value_o   (amp_value_o)
  );

  // Advance the stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_v_q  <= 1'b0;
      avg_v_q  <= 1'b0;
      prod_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (blk_rdy)  blk_v_q  <= accept && last;
      if (avg_rdy)  avg_v_q  <= blk_v_q;
      if (prod_rdy) prod_v_q <= avg_v_q;
      if (out_rdy)  out_v_q  <= prod_v_q;
    end
  end

  assign out_valid_o = out_v_q;

  a_blk_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(blk_v_q) |-> $past(accept && last))
    else $error("block stage filled without a closing item");

  a_prod_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_stall_i && prod_v_q) |=> prod_v_q)
    else $error("product stage dropped an item under stall");

endmodule

// ----- design/dcbac_regs.sv -----
// APB-style configuration registers: biases and gains of both channels.
// Depends on dcbac_pkg.
module dcbac_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dcbac_pkg::ADDR_W-1:0]  paddr,
  input  logic [dcbac_pkg::DATA_W-1:0]  pwdata,
  output logic [dcbac_pkg::DATA_W-1:0]  prdata,
  output logic                          pready,
  output dcbac_pkg::cfg_t               cfg_o
);
  import dcbac_pkg::*;

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign cfg_o  = cfg_q;

  // Write the addressed register, keeping the low 15 bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.volt_bias <= BIAS_RESET;
      cfg_q.volt_gain <= GAIN_RESET;
      cfg_q.amp_bias  <= BIAS_RESET;
      cfg_q.amp_gain  <= GAIN_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_VOLT_BIAS: cfg_q.volt_bias <= pwdata[REG_W-1:0];
        REG_VOLT_GAIN: cfg_q.volt_gain <= pwdata[REG_W-1:0];
        REG_AMP_BIAS:  cfg_q.amp_bias  <= pwdata[REG_W-1:0];
        REG_AMP_GAIN:  cfg_q.amp_gain  <= pwdata[REG_W-1:0];
        default:       ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (idx)
      REG_VOLT_BIAS: prdata = DATA_W'(cfg_q.volt_bias);
      REG_VOLT_GAIN: prdata = DATA_W'(cfg_q.volt_gain);
      REG_AMP_BIAS:  prdata = DATA_W'(cfg_q.amp_bias);
      REG_AMP_GAIN:  prdata = DATA_W'(cfg_q.amp_gain);
      default:       prdata = '0;
    endcase
  end

endmodule

// ----- design/dcbac_accum.sv -----
// Running sums and sample counter of both channels; captures the finished
// block sums when the last sample of a block arrives. Depends on dcbac_pkg.
module dcbac_accum #(
  parameter int BLOCK_LEN = 50
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            accept_i,
  input  logic [dcbac_pkg::SAMPLE_W-1:0]  volt_sample_i,
  input  logic [dcbac_pkg::SAMPLE_W-1:0]  amp_sample_i,
  output logic                            last_o,
  output logic [dcbac_pkg::SUM_W-1:0]     volt_blk_o,
  output logic [dcbac_pkg::SUM_W-1:0]     amp_blk_o
);
  import dcbac_pkg::*;

  localparam int CNT_W = (BLOCK_LEN > 2) ? $clog2(BLOCK_LEN) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BLOCK_LEN - 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [SUM_W-1:0] vsum_q, vsum_d, asum_q, asum_d;
  logic [SUM_W-1:0] vadd, aadd;
  logic [SUM_W-1:0] vblk_q, ablk_q;

  assign last_o     = (cnt_q == CNT_LAST);
  assign vadd       = vsum_q + SUM_W'(volt_sample_i);
  assign aadd       = asum_q + SUM_W'(amp_sample_i);
  assign volt_blk_o = vblk_q;
  assign amp_blk_o  = ablk_q;

  // Accumulate, or clear at the end of a block
  always_comb begin
    cnt_d  = cnt_q;
    vsum_d = vsum_q;
    asum_d = asum_q;
    if (accept_i) begin
      if (last_o) begin
        cnt_d  = '0;
        vsum_d = '0;
        asum_d = '0;
      end else begin
        cnt_d  = cnt_q + 1'b1;
        vsum_d = vadd;
        asum_d = aadd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      vsum_q <= '0;
      asum_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      vsum_q <= vsum_d;
      asum_q <= asum_d;
    end
  end

  // Hold the finished block sums for the divide stage
  always_ff @(posedge clk_i) begin
    if (accept_i && last_o) begin
      vblk_q <= vadd;
      ablk_q <= aadd;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_LAST) else $error("sample counter passed block length");

  a_cnt_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && last_o) |=> (cnt_q == '0 && vsum_q == '0 && asum_q == '0))
    else $error("block end did not clear sums and counter");

endmodule

// ----- design/dcbac_chan.sv -----
// Datapath of one channel: divide the block sum by the block length
// (reciprocal multiply), subtract bias, multiply by gain, saturate.
// Depends on dcbac_pkg.
module dcbac_chan #(
  parameter int BLOCK_LEN = 50
) (
  input  logic                          clk_i,
  input  logic                          avg_en_i,
  input  logic                          prod_en_i,
  input  logic                          out_en_i,
  input  logic [dcbac_pkg::SUM_W-1:0]   blk_sum_i,
  input  logic [dcbac_pkg::REG_W-1:0]   bias_i,
  input  logic [dcbac_pkg::REG_W-1:0]   gain_i,
  output logic [dcbac_pkg::OUT_W-1:0]   value_o
);
  import dcbac_pkg::*;

  // Exact floor division for any SUM_W-bit dividend
  localparam int  SHIFT   = SUM_W + $clog2(BLOCK_LEN);
  localparam int  RECIP_W = SUM_W + 1;
  localparam int  MUL_W   = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + 64'(BLOCK_LEN) - 64'd1) / 64'(BLOCK_LEN));

  logic [MUL_W-1:0]          quot_full;
  logic [AVG_W-1:0]          avg_q;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [PROD_W-1:0]  diff_x, gain_x, prod_d, prod_q;
  logic [OUT_W-1:0]          sat_d, out_q;

  assign quot_full = MUL_W'(blk_sum_i) * MUL_W'(RECIP);

  // Average of the block
  always_ff @(posedge clk_i) begin
    if (avg_en_i) avg_q <= quot_full[SHIFT +: AVG_W];
  end

  // Remove bias and apply gain
  assign diff   = $signed(DIFF_W'(avg_q))
                - $signed({{(DIFF_W-REG_W){bias_i[REG_W-1]}}, bias_i});
  assign diff_x = PROD_W'(diff);
  assign gain_x = $signed(PROD_W'(gain_i));
  assign prod_d = diff_x * gain_x;

  always_ff @(posedge clk_i) begin
    if (prod_en_i) prod_q <= prod_d;
  end

  // Clamp to the signed result range
  always_comb begin
    if (prod_q > OUT_MAX)      sat_d = OUT_MAX[OUT_W-1:0];
    else if (prod_q < OUT_MIN) sat_d = OUT_MIN[OUT_W-1:0];
    else                       sat_d = prod_q[OUT_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (out_en_i) out_q <= sat_d;
  end

  assign value_o = out_q;

endmodule
